FILE: rtl/vngl_pkg.sv
// ----------------------------------------------------------------------------
// vngl_pkg: shared constants for the Gouraud vertex lighting block
// Field widths, command codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package vngl_pkg;

  // vertex store and accumulator geometry
  localparam int VIDX_W   = 10;
  localparam int VDEPTH   = 2 ** VIDX_W;
  localparam int VERTICES = 1024;
  localparam int COORD_W  = 12;
  localparam int SUM_W    = 26;
  localparam int FCNT_W   = 16;
  localparam int NREC_W   = 3 * SUM_W + FCNT_W;

  // datapath widths
  localparam int DIFF_W  = COORD_W + 1;
  localparam int N_W     = 2 * DIFF_W + 1;
  localparam int MUL_W   = 27;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int SQS_W   = 56;
  localparam int ROOT_W  = SQS_W / 2;
  localparam int DEN_W   = 28;
  localparam int QUO_W   = 38;
  localparam int ACC_W   = 39;
  localparam int QN_W    = 10;
  localparam int LUM_W   = 18;
  localparam int NQ_BITS = 9;
  localparam int NSCALE  = 8;

  // command codes
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_ACCUM = 2'd1;
  localparam logic [1:0] CMD_LIGHT = 2'd2;
  localparam logic [1:0] FACE_SKIP = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTEN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LX      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LY      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LZ      = 3'd4;

  // register reset values
  localparam logic [7:0]         AMB_RST = 8'd64;
  localparam logic [11:0]        ATT_RST = 12'd768;
  localparam logic signed [10:0] LX_RST  = -11'sd50;
  localparam logic signed [10:0] LY_RST  = -11'sd10;
  localparam logic signed [10:0] LZ_RST  = -11'sd50;

  // color handling
  localparam logic [15:0] HSL_HI_MASK = 16'hff80;
  localparam int SHADE_SH  = 7;
  localparam int SHADE_MIN = 2;
  localparam int SHADE_MAX = 126;
  localparam int LUM_MAX   = 65535;
  localparam int LUM_MIN   = -65536;

endpackage

`default_nettype wire

FILE: rtl/vertex_normal_gouraud_lighting.sv
// ----------------------------------------------------------------------------
// vertex_normal_gouraud_lighting: per-vertex normal accumulation and lighting
// Vertex store, normal accumulators and one sequencer around a shared
// multiplier, a shift-subtract square root and a shared restoring divider.
// ----------------------------------------------------------------------------
// Load writes the vertex store on acceptance; accumulate runs 28 root steps
// and three normal divides; light runs a 38-step divide per corner with faces.
// One word in flight at a time; a finished result waits in the output
// register while the next word is taken.
// After reset a clearing pass over all 1024 entries zeroes the accumulators;
// the input stalls meanwhile. Configuration registers reset to their defaults.
`default_nettype none

module vertex_normal_gouraud_lighting (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [vngl_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [vngl_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [1:0]                          command_i,
  input  wire logic [9:0]                          first_index_i,
  input  wire logic [9:0]                          second_index_i,
  input  wire logic [9:0]                          third_index_i,
  input  wire logic signed [11:0]                  pos_x_i,
  input  wire logic signed [11:0]                  pos_y_i,
  input  wire logic signed [11:0]                  pos_z_i,
  input  wire logic [15:0]                         flat_color_i,
  input  wire logic [1:0]                          face_type_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [15:0]                              color_a_o,
  output logic [15:0]                              color_b_o,
  output logic [15:0]                              color_c_o,
  output logic                                     skipped_o
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_VRD   = 4'd2;
  localparam logic [3:0] S_CROSS = 4'd3;
  localparam logic [3:0] S_SQ    = 4'd4;
  localparam logic [3:0] S_SQRT  = 4'd5;
  localparam logic [3:0] S_NDIV  = 4'd6;
  localparam logic [3:0] S_NACC  = 4'd7;
  localparam logic [3:0] S_LRD   = 4'd8;
  localparam logic [3:0] S_DOT   = 4'd9;
  localparam logic [3:0] S_LDIV  = 4'd10;
  localparam logic [3:0] S_SHADE = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  localparam int VIDX_W = vngl_pkg::VIDX_W;
  localparam int COORD_W = vngl_pkg::COORD_W;
  localparam int SUM_W = vngl_pkg::SUM_W;
  localparam int FCNT_W = vngl_pkg::FCNT_W;
  localparam int MUL_W = vngl_pkg::MUL_W;
  localparam int DEN_W = vngl_pkg::DEN_W;
  localparam int QUO_W = vngl_pkg::QUO_W;
  localparam int ACC_W = vngl_pkg::ACC_W;

  // control
  logic [3:0]        state_q;
  logic [5:0]        cnt_q;
  logic [1:0]        k_q;
  logic              ph_q;
  logic [VIDX_W-1:0] clr_q;
  logic              accept;

  // configuration
  logic [7:0]         amb_q;
  logic [11:0]        att_q;
  logic signed [10:0] lx_q, ly_q, lz_q;

  // word registers
  logic [VIDX_W-1:0] idx_q [3];
  logic [15:0]       hsl_q;
  logic [15:0]       col_q [3];
  logic              skip_q;

  // output register
  logic        out_valid_q;
  logic [15:0] out_a_q, out_b_q, out_c_q;
  logic        out_skip_q;

  // memories
  logic [3*COORD_W-1:0]        vmem [vngl_pkg::VDEPTH];
  logic [3*COORD_W-1:0]        vrd_q;
  logic                        vmem_we;
  logic [VIDX_W-1:0]           vaddr;
  logic [vngl_pkg::NREC_W-1:0] nmem [vngl_pkg::VDEPTH];
  logic [vngl_pkg::NREC_W-1:0] nrd_q;
  logic                        nmem_we;
  logic [VIDX_W-1:0]           naddr;
  logic [vngl_pkg::NREC_W-1:0] nwdata;

  // geometry
  logic signed [COORD_W-1:0]          vx_q [3];
  logic signed [COORD_W-1:0]          vy_q [3];
  logic signed [COORD_W-1:0]          vz_q [3];
  logic signed [vngl_pkg::DIFF_W-1:0] abx, aby, abz, acx, acy, acz;
  logic signed [vngl_pkg::N_W-1:0]    n_q [3];
  logic [vngl_pkg::SQS_W-1:0]         sum_q;
  logic signed [vngl_pkg::QN_W-1:0]   qn_q [3];
  logic [1:0]                         vsel;
  logic [2:0]                         pidx;

  // shared multiplier
  logic signed [MUL_W-1:0]            mul_a, mul_b;
  logic signed [vngl_pkg::PROD_W-1:0] prod_q;

  // square root
  logic [vngl_pkg::SQS_W-1:0]  sq_src_q;
  logic [ROOT_W_L-1:0]         sq_root_q;
  logic [ROOT_W_L+1:0]         sq_rem_q;
  logic [ROOT_W_L+1:0]         sq_remv, sq_trial;
  logic                        sq_ge;
  localparam int ROOT_W_L = vngl_pkg::ROOT_W;

  // shared divider
  logic [DEN_W-1:0] den_q;
  logic [DEN_W-1:0] rem_q;
  logic [QUO_W-1:0] quo_q;
  logic [5:0]       dcnt_q;
  logic             dbusy_q;
  logic             neg_q;
  logic [DEN_W:0]   dtr;
  logic             dge;
  logic [DEN_W-1:0] rem_d;

  // lighting
  logic signed [SUM_W-1:0]           sx_q, sy_q, sz_q;
  logic [FCNT_W-1:0]                 fc_q;
  logic signed [ACC_W-1:0]           acc_q;
  logic [QUO_W-1:0]                  acc_mag;
  logic signed [vngl_pkg::LUM_W-1:0] lum_q;
  logic signed [ACC_W:0]             lq;
  logic signed [ACC_W:0]             lsum;
  logic signed [vngl_pkg::PROD_W-1:0] shade;
  logic [15:0]                       col_new;
  logic [N_W_L-1:0]                  n_mag;
  localparam int N_W_L = vngl_pkg::N_W;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  assign out_valid_o = out_valid_q;
  assign color_a_o   = out_a_q;
  assign color_b_o   = out_b_q;
  assign color_c_o   = out_c_q;
  assign skipped_o   = out_skip_q;

  // edge vectors of the face
  assign abx = vngl_pkg::DIFF_W'(vx_q[1]) - vngl_pkg::DIFF_W'(vx_q[0]);
  assign aby = vngl_pkg::DIFF_W'(vy_q[1]) - vngl_pkg::DIFF_W'(vy_q[0]);
  assign abz = vngl_pkg::DIFF_W'(vz_q[1]) - vngl_pkg::DIFF_W'(vz_q[0]);
  assign acx = vngl_pkg::DIFF_W'(vx_q[2]) - vngl_pkg::DIFF_W'(vx_q[0]);
  assign acy = vngl_pkg::DIFF_W'(vy_q[2]) - vngl_pkg::DIFF_W'(vy_q[0]);
  assign acz = vngl_pkg::DIFF_W'(vz_q[2]) - vngl_pkg::DIFF_W'(vz_q[0]);

  assign vsel = 2'(cnt_q - 6'd1);
  assign pidx = 3'(cnt_q - 6'd1);

  // square root step: two radicand bits per cycle
  assign sq_remv  = {sq_rem_q[ROOT_W_L-1:0], sq_src_q[vngl_pkg::SQS_W-1 -: 2]};
  assign sq_trial = {sq_root_q, 2'b01};
  assign sq_ge    = (sq_remv >= sq_trial);

  // divider step: one quotient bit per cycle
  assign dtr   = {rem_q, quo_q[QUO_W-1]};
  assign dge   = (dtr >= {1'b0, den_q});
  assign rem_d = dge ? DEN_W'(dtr - {1'b0, den_q}) : DEN_W'(dtr);

  // magnitudes for the divider
  assign n_mag   = n_q[k_q][N_W_L-1] ? N_W_L'(-n_q[k_q]) : N_W_L'(n_q[k_q]);
  assign acc_mag = acc_q[ACC_W-1] ? QUO_W'(-acc_q) : QUO_W'(acc_q);

  // lightness: ambient plus signed quotient
  assign lq   = neg_q ? -(ACC_W+1)'({1'b0, quo_q}) : (ACC_W+1)'({1'b0, quo_q});
  assign lsum = (ACC_W+1)'(amb_q) + lq;

  // shaded lightness and corner color
  assign shade = prod_q >>> vngl_pkg::SHADE_SH;
  always_comb begin
    col_new = hsl_q & vngl_pkg::HSL_HI_MASK;
    if (shade < vngl_pkg::PROD_W'(vngl_pkg::SHADE_MIN)) begin
      col_new = col_new + 16'(vngl_pkg::SHADE_MIN);
    end else if (shade > vngl_pkg::PROD_W'(vngl_pkg::SHADE_MAX)) begin
      col_new = col_new + 16'(vngl_pkg::SHADE_MAX);
    end else begin
      col_new = col_new + 16'(shade[6:0]);
    end
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_CROSS: begin
        unique case (cnt_q)
          6'd0: begin mul_a = MUL_W'(aby); mul_b = MUL_W'(acz); end
          6'd1: begin mul_a = MUL_W'(acy); mul_b = MUL_W'(abz); end
          6'd2: begin mul_a = MUL_W'(abz); mul_b = MUL_W'(acx); end
          6'd3: begin mul_a = MUL_W'(acz); mul_b = MUL_W'(abx); end
          6'd4: begin mul_a = MUL_W'(abx); mul_b = MUL_W'(acy); end
          6'd5: begin mul_a = MUL_W'(acx); mul_b = MUL_W'(aby); end
          default: ;
        endcase
      end
      S_SQ: begin
        unique case (cnt_q)
          6'd0: begin mul_a = MUL_W'(n_q[0]); mul_b = MUL_W'(n_q[0]); end
          6'd1: begin mul_a = MUL_W'(n_q[1]); mul_b = MUL_W'(n_q[1]); end
          6'd2: begin mul_a = MUL_W'(n_q[2]); mul_b = MUL_W'(n_q[2]); end
          default: ;
        endcase
      end
      S_DOT: begin
        unique case (cnt_q)
          6'd0: begin mul_a = MUL_W'(lx_q); mul_b = MUL_W'(sx_q); end
          6'd1: begin mul_a = MUL_W'(ly_q); mul_b = MUL_W'(sy_q); end
          6'd2: begin mul_a = MUL_W'(lz_q); mul_b = MUL_W'(sz_q); end
          6'd3: begin mul_a = MUL_W'(att_q); mul_b = MUL_W'(fc_q); end
          default: ;
        endcase
      end
      S_SHADE: begin
        mul_a = MUL_W'(lum_q);
        mul_b = MUL_W'(hsl_q[6:0]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // vertex store: one write, one registered read
  assign vmem_we = accept && (command_i == vngl_pkg::CMD_LOAD) &&
                   (32'(first_index_i) < vngl_pkg::VERTICES);
  always_comb begin
    unique case (cnt_q[1:0])
      2'd0:    vaddr = idx_q[0];
      2'd1:    vaddr = idx_q[1];
      default: vaddr = idx_q[2];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (vmem_we) begin
      vmem[first_index_i] <= {pos_z_i, pos_y_i, pos_x_i};
    end
    vrd_q <= vmem[vaddr];
  end

  // accumulator store: clear, read-modify-write
  always_comb begin
    nmem_we = 1'b0;
    naddr   = idx_q[k_q];
    nwdata  = '0;
    if (state_q == S_CLR) begin
      nmem_we = 1'b1;
      naddr   = clr_q;
    end else if (state_q == S_NACC && ph_q) begin
      nmem_we = 1'b1;
      nwdata  = {nrd_q[3*SUM_W +: FCNT_W] + FCNT_W'(1),
                 nrd_q[2*SUM_W +: SUM_W] + SUM_W'(qn_q[2]),
                 nrd_q[SUM_W +: SUM_W] + SUM_W'(qn_q[1]),
                 nrd_q[0 +: SUM_W] + SUM_W'(qn_q[0])};
    end
  end

  always_ff @(posedge clk_i) begin
    if (nmem_we) begin
      nmem[naddr] <= nwdata;
    end
    nrd_q <= nmem[naddr];
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amb_q <= vngl_pkg::AMB_RST;
      att_q <= vngl_pkg::ATT_RST;
      lx_q  <= vngl_pkg::LX_RST;
      ly_q  <= vngl_pkg::LY_RST;
      lz_q  <= vngl_pkg::LZ_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        vngl_pkg::CFG_AMBIENT: amb_q <= cfg_data_i[7:0];
        vngl_pkg::CFG_ATTEN:   att_q <= cfg_data_i[11:0];
        vngl_pkg::CFG_LX:      lx_q  <= cfg_data_i[10:0];
        vngl_pkg::CFG_LY:      ly_q  <= cfg_data_i[10:0];
        vngl_pkg::CFG_LZ:      lz_q  <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          idx_q[0] <= first_index_i;
          idx_q[1] <= second_index_i;
          idx_q[2] <= third_index_i;
          hsl_q    <= flat_color_i;
          skip_q   <= (face_type_i == vngl_pkg::FACE_SKIP);
          col_q[0] <= '0;
          col_q[1] <= '0;
          col_q[2] <= '0;
        end
      end
      S_VRD: begin
        if (cnt_q != 6'd0) begin
          vx_q[vsel] <= vrd_q[0 +: COORD_W];
          vy_q[vsel] <= vrd_q[COORD_W +: COORD_W];
          vz_q[vsel] <= vrd_q[2*COORD_W +: COORD_W];
        end
      end
      S_CROSS: begin
        if (cnt_q != 6'd0) begin
          if (!pidx[0]) begin
            n_q[pidx[2:1]] <= prod_q[N_W_L-1:0];
          end else begin
            n_q[pidx[2:1]] <= n_q[pidx[2:1]] - prod_q[N_W_L-1:0];
          end
        end
        sum_q <= '0;
      end
      S_SQ: begin
        if (cnt_q != 6'd0) begin
          sum_q <= sum_q + vngl_pkg::SQS_W'(prod_q);
        end
        if (cnt_q == 6'd3) begin
          sq_src_q  <= sum_q + vngl_pkg::SQS_W'(prod_q);
          sq_rem_q  <= '0;
          sq_root_q <= '0;
        end
      end
      S_SQRT: begin
        if (cnt_q == 6'(ROOT_W_L)) begin
          den_q   <= (sq_root_q == '0) ? DEN_W'(1) : DEN_W'(sq_root_q);
          dbusy_q <= 1'b0;
        end else begin
          sq_src_q  <= sq_src_q << 2;
          sq_rem_q  <= sq_ge ? (sq_remv - sq_trial) : sq_remv;
          sq_root_q <= {sq_root_q[ROOT_W_L-2:0], sq_ge};
        end
      end
      S_NDIV: begin
        if (!dbusy_q) begin
          // normal * 256 / m: quotient fits nine bits since m >= |n|
          rem_q   <= DEN_W'(n_mag >> 1);
          quo_q   <= {n_mag[0], (QUO_W-1)'(0)};
          neg_q   <= n_q[k_q][N_W_L-1];
          dcnt_q  <= 6'(vngl_pkg::NQ_BITS);
          dbusy_q <= 1'b1;
        end else if (dcnt_q != 6'd0) begin
          rem_q  <= rem_d;
          quo_q  <= {quo_q[QUO_W-2:0], dge};
          dcnt_q <= dcnt_q - 6'd1;
        end else begin
          qn_q[k_q] <= neg_q ? -vngl_pkg::QN_W'(quo_q[vngl_pkg::NQ_BITS-1:0])
                             : vngl_pkg::QN_W'(quo_q[vngl_pkg::NQ_BITS-1:0]);
          dbusy_q   <= 1'b0;
        end
      end
      S_LRD: begin
        if (ph_q) begin
          sx_q <= nrd_q[0 +: SUM_W];
          sy_q <= nrd_q[SUM_W +: SUM_W];
          sz_q <= nrd_q[2*SUM_W +: SUM_W];
          fc_q <= (32'(idx_q[k_q]) < vngl_pkg::VERTICES) ?
                  nrd_q[3*SUM_W +: FCNT_W] : '0;
          lum_q <= vngl_pkg::LUM_W'(amb_q);
        end
      end
      S_DOT: begin
        unique case (cnt_q)
          6'd1: acc_q <= prod_q[ACC_W-1:0];
          6'd2, 6'd3: acc_q <= acc_q + prod_q[ACC_W-1:0];
          6'd4: begin
            den_q  <= prod_q[DEN_W-1:0];
            rem_q  <= '0;
            quo_q  <= acc_mag;
            neg_q  <= acc_q[ACC_W-1];
            dcnt_q <= 6'(QUO_W);
          end
          default: ;
        endcase
      end
      S_LDIV: begin
        if (dcnt_q != 6'd0) begin
          rem_q  <= rem_d;
          quo_q  <= {quo_q[QUO_W-2:0], dge};
          dcnt_q <= dcnt_q - 6'd1;
        end else if (lsum > (ACC_W+1)'(vngl_pkg::LUM_MAX)) begin
          lum_q <= vngl_pkg::LUM_W'(vngl_pkg::LUM_MAX);
        end else if (lsum < (ACC_W+1)'(vngl_pkg::LUM_MIN)) begin
          lum_q <= vngl_pkg::LUM_W'(vngl_pkg::LUM_MIN);
        end else begin
          lum_q <= lsum[vngl_pkg::LUM_W-1:0];
        end
      end
      S_SHADE: begin
        if (cnt_q != 6'd0) begin
          col_q[k_q] <= col_new;
        end
      end
      default: ;
    endcase
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      cnt_q       <= '0;
      k_q         <= '0;
      ph_q        <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      out_a_q     <= '0;
      out_b_q     <= '0;
      out_c_q     <= '0;
      out_skip_q  <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLR: begin
          clr_q <= clr_q + VIDX_W'(1);
          if (&clr_q) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          cnt_q <= '0;
          k_q   <= '0;
          ph_q  <= 1'b0;
          if (accept) begin
            if (command_i == vngl_pkg::CMD_ACCUM) begin
              if ((32'(first_index_i) < vngl_pkg::VERTICES) &&
                  (32'(second_index_i) < vngl_pkg::VERTICES) &&
                  (32'(third_index_i) < vngl_pkg::VERTICES)) begin
                state_q <= S_VRD;
              end
            end else if (command_i == vngl_pkg::CMD_LIGHT) begin
              state_q <= (face_type_i == vngl_pkg::FACE_SKIP) ? S_OUT : S_LRD;
            end
          end
        end
        S_VRD, S_CROSS, S_SQ: begin
          cnt_q <= cnt_q + 6'd1;
          if ((state_q == S_VRD && cnt_q == 6'd3) ||
              (state_q == S_CROSS && cnt_q == 6'd6) ||
              (state_q == S_SQ && cnt_q == 6'd3)) begin
            cnt_q   <= '0;
            state_q <= (state_q == S_VRD) ? S_CROSS :
                       (state_q == S_CROSS) ? S_SQ : S_SQRT;
          end
        end
        S_SQRT: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(ROOT_W_L)) begin
            cnt_q   <= '0;
            k_q     <= '0;
            state_q <= S_NDIV;
          end
        end
        S_NDIV: begin
          if (dbusy_q && dcnt_q == 6'd0) begin
            if (k_q == 2'd2) begin
              k_q     <= '0;
              ph_q    <= 1'b0;
              state_q <= S_NACC;
            end else begin
              k_q <= k_q + 2'd1;
            end
          end
        end
        S_NACC: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            if (k_q == 2'd2) begin
              state_q <= S_IDLE;
            end else begin
              k_q <= k_q + 2'd1;
            end
          end
        end
        S_LRD: begin
          ph_q  <= !ph_q;
          cnt_q <= '0;
          if (ph_q) begin
            // empty accumulator or zero attenuation: ambient alone
            if ((nrd_q[3*SUM_W +: FCNT_W] == '0) || (att_q == '0) ||
                !(32'(idx_q[k_q]) < vngl_pkg::VERTICES)) begin
              state_q <= S_SHADE;
            end else begin
              state_q <= S_DOT;
            end
          end
        end
        S_DOT: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd4) begin
            state_q <= S_LDIV;
          end
        end
        S_LDIV: begin
          cnt_q <= '0;
          if (dcnt_q == 6'd0) begin
            state_q <= S_SHADE;
          end
        end
        S_SHADE: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q != 6'd0) begin
            cnt_q <= '0;
            ph_q  <= 1'b0;
            if (k_q == 2'd2) begin
              state_q <= S_OUT;
            end else begin
              k_q     <= k_q + 2'd1;
              state_q <= S_LRD;
            end
          end
        end
        S_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_a_q     <= col_q[0];
            out_b_q     <= col_q[1];
            out_c_q     <= col_q[2];
            out_skip_q  <= skip_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: bench/tb_vertex_normal_gouraud_lighting.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vertex_normal_gouraud_lighting: self-checking bench for vertex lighting
// Drives load, accumulate and light words with random idling on both sides.
// A behavioral copy of the vertex store and normal accumulators predicts each
// lit face, and every output word is compared field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_vertex_normal_gouraud_lighting;
  import vngl_pkg::*;

  localparam logic [1:0] CMD_NONE   = 2'd3;
  localparam int         WDOG_LIMIT = 6000;
  localparam int         DRAIN_WAIT = 200;
  localparam int         HOLD_LEN   = 400;
  localparam int         RAND_WORDS = 800;

  typedef struct {
    logic [1:0]         cmd;
    logic [9:0]         ia, ib, ic;
    logic signed [11:0] px, py, pz;
    logic [15:0]        hsl;
    logic [1:0]         ftype;
  } face_word_t;

  typedef struct {
    logic [15:0] ca, cb, cc;
    logic        skip;
  } lit_face_t;

  typedef struct {
    face_word_t w;
    bit         typed;
    lit_face_t  res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] command_i = '0;
  logic [9:0] first_index_i = '0, second_index_i = '0, third_index_i = '0;
  logic signed [11:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic [15:0] flat_color_i = '0;
  logic [1:0] face_type_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [15:0] color_a_o, color_b_o, color_c_o;
  logic skipped_o;

  vertex_normal_gouraud_lighting dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state: vertex store, normal sums, face counts, registers
  longint             vtx_x [VERTICES], vtx_y [VERTICES], vtx_z [VERTICES];
  bit                 vtx_loaded [VERTICES];
  int                 loaded_ids [$];
  logic signed [25:0] nsum_x [VERTICES], nsum_y [VERTICES], nsum_z [VERTICES];
  logic [15:0]        face_cnt [VERTICES];
  logic [7:0]         amb_lvl;
  logic [11:0]        atten_lvl;
  logic signed [10:0] lite_x, lite_y, lite_z;

  lit_face_t pending_faces [$];
  int  errors = 0, n_load = 0, n_accum = 0, n_light = 0, n_skip = 0, n_checked = 0;
  bit  quiet = 1'b0;
  bit  hold_req = 1'b0;
  int  idle_cycles = 0;

  function automatic longint root_floor(longint sq);
    longint r, t;
    r = 0;
    for (int b = 27; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= sq) r = t;
    end
    return r;
  endfunction

  // fold one face normal into all three corners
  task automatic fold_face_normal(int a, int b, int c);
    longint abx, aby, abz, acx, acy, acz, nx, ny, nz, m;
    int idx [3];
    abx = vtx_x[b] - vtx_x[a]; aby = vtx_y[b] - vtx_y[a]; abz = vtx_z[b] - vtx_z[a];
    acx = vtx_x[c] - vtx_x[a]; acy = vtx_y[c] - vtx_y[a]; acz = vtx_z[c] - vtx_z[a];
    nx = aby * acz - acy * abz;
    ny = abz * acx - acz * abx;
    nz = abx * acy - acx * aby;
    m = root_floor(nx * nx + ny * ny + nz * nz);
    if (m <= 0) m = 1;
    nx = (nx * 256) / m;
    ny = (ny * 256) / m;
    nz = (nz * 256) / m;
    idx = '{a, b, c};
    foreach (idx[k]) begin
      nsum_x[idx[k]] = nsum_x[idx[k]] + nx[25:0];
      nsum_y[idx[k]] = nsum_y[idx[k]] + ny[25:0];
      nsum_z[idx[k]] = nsum_z[idx[k]] + nz[25:0];
      face_cnt[idx[k]] = face_cnt[idx[k]] + 16'd1;
    end
  endtask

  function automatic logic [15:0] shade_corner(int v, logic [15:0] hsl);
    longint lum, den, dot, p, s;
    lum = amb_lvl;
    den = longint'(atten_lvl) * longint'(face_cnt[v]);
    if (den > 0) begin
      dot = longint'(lite_x) * longint'(nsum_x[v]) + longint'(lite_y) * longint'(nsum_y[v])
          + longint'(lite_z) * longint'(nsum_z[v]);
      lum += dot / den;
    end
    p = lum * longint'(hsl[6:0]);
    s = (p >= 0) ? p / 128 : -((-p + 127) / 128);
    if (s < SHADE_MIN) s = SHADE_MIN;
    else if (s > SHADE_MAX) s = SHADE_MAX;
    return (hsl & HSL_HI_MASK) + s[15:0];
  endfunction

  // apply one accepted word to the predictor; light words queue a result
  task automatic track_word(face_word_t w, bit typed, lit_face_t typed_res);
    lit_face_t r;
    case (w.cmd)
      CMD_LOAD: begin
        vtx_x[w.ia] = w.px; vtx_y[w.ia] = w.py; vtx_z[w.ia] = w.pz;
        if (!vtx_loaded[w.ia]) loaded_ids.push_back(w.ia);
        vtx_loaded[w.ia] = 1'b1;
        n_load++;
      end
      CMD_ACCUM: begin
        fold_face_normal(w.ia, w.ib, w.ic);
        n_accum++;
      end
      CMD_LIGHT: begin
        if (w.ftype == FACE_SKIP) begin
          r = '{16'd0, 16'd0, 16'd0, 1'b1};
          n_skip++;
        end else begin
          r.ca = shade_corner(w.ia, w.hsl);
          r.cb = shade_corner(w.ib, w.hsl);
          r.cc = shade_corner(w.ic, w.hsl);
          r.skip = 1'b0;
        end
        pending_faces.push_back(typed ? typed_res : r);
        n_light++;
      end
      default: ;
    endcase
  endtask

  // present one word, wait for acceptance, then maybe idle
  task automatic send_word(face_word_t w, bit typed = 0, lit_face_t typed_res = '{0, 0, 0, 0});
    command_i = w.cmd;
    first_index_i = w.ia; second_index_i = w.ib; third_index_i = w.ic;
    pos_x_i = w.px; pos_y_i = w.py; pos_z_i = w.pz;
    flat_color_i = w.hsl; face_type_i = w.ftype;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    track_word(w, typed, typed_res);
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i = 1'b1; cfg_idx_i = idx; cfg_data_i = data;
    case (idx)
      CFG_AMBIENT: amb_lvl = data[7:0];
      CFG_ATTEN:   atten_lvl = data;
      CFG_LX:      lite_x = data[10:0];
      CFG_LY:      lite_y = data[10:0];
      CFG_LZ:      lite_z = data[10:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_lighting(int amb, int att, int lx, int ly, int lz);
    write_reg(CFG_AMBIENT, CFG_DATA_W'(amb));
    write_reg(CFG_ATTEN, CFG_DATA_W'(att));
    write_reg(CFG_LX, CFG_DATA_W'(lx));
    write_reg(CFG_LY, CFG_DATA_W'(ly));
    write_reg(CFG_LZ, CFG_DATA_W'(lz));
  endtask

  // wait for all lit faces, then for any accumulate still in progress
  task automatic settle();
    in_valid_i = 1'b0;
    while (pending_faces.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  function automatic face_word_t rand_word();
    face_word_t w;
    int sel;
    w.ia = $urandom; w.ib = $urandom; w.ic = $urandom;
    w.px = $urandom; w.py = $urandom; w.pz = $urandom;
    w.hsl = $urandom; w.ftype = $urandom;
    sel = $urandom_range(0, 99);
    if (sel < 30 || loaded_ids.size() == 0) begin
      w.cmd = CMD_LOAD;
      if ($urandom_range(0, 4) != 0) w.ia = $urandom_range(0, 63);
    end else if (sel < 65) begin
      w.cmd = CMD_ACCUM;
      w.ia = loaded_ids[$urandom_range(0, loaded_ids.size() - 1)];
      w.ib = loaded_ids[$urandom_range(0, loaded_ids.size() - 1)];
      w.ic = loaded_ids[$urandom_range(0, loaded_ids.size() - 1)];
    end else if (sel < 97) begin
      w.cmd = CMD_LIGHT;
      if ($urandom_range(0, 3) != 0) begin
        w.ia = $urandom_range(0, 63); w.ib = $urandom_range(0, 63);
        w.ic = $urandom_range(0, 63);
      end
    end else begin
      w.cmd = CMD_NONE;
    end
    return w;
  endfunction

  // receiver: random stall bursts plus one long hold-off on request
  int burst_left = 0, hold_left = 0;
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i = 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      out_stall_i = 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      burst_left = $urandom_range(0, 17);
      out_stall_i = 1'b1;
    end else begin
      out_stall_i = 1'b0;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    lit_face_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_faces.size() == 0) begin
        $display("%0t: unexpected lit face word a=%h b=%h c=%h skip=%b", $time,
                 color_a_o, color_b_o, color_c_o, skipped_o);
        errors++;
      end else begin
        e = pending_faces.pop_front();
        n_checked++;
        if (color_a_o !== e.ca) begin
          $display("%0t: color_a expected %h actual %h", $time, e.ca, color_a_o);
          errors++;
        end
        if (color_b_o !== e.cb) begin
          $display("%0t: color_b expected %h actual %h", $time, e.cb, color_b_o);
          errors++;
        end
        if (color_c_o !== e.cc) begin
          $display("%0t: color_c expected %h actual %h", $time, e.cc, color_c_o);
          errors++;
        end
        if (skipped_o !== e.skip) begin
          $display("%0t: skipped expected %b actual %b", $time, e.skip, skipped_o);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d lit faces outstanding", $time,
               pending_faces.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  stim_row_t dir_rows [$];

  function automatic stim_row_t row(logic [1:0] cmd, int a, int b, int c, int x, int y,
                                    int z, int hsl, int ft, bit typed = 0,
                                    lit_face_t res = '{0, 0, 0, 0});
    stim_row_t r;
    r.w = '{cmd, a[9:0], b[9:0], c[9:0], x[11:0], y[11:0], z[11:0], hsl[15:0], ft[1:0]};
    r.typed = typed;
    r.res = res;
    return r;
  endfunction

  initial begin
    face_word_t w;
    for (int i = 0; i < VERTICES; i++) begin
      vtx_x[i] = 0; vtx_y[i] = 0; vtx_z[i] = 0; vtx_loaded[i] = 0;
      nsum_x[i] = '0; nsum_y[i] = '0; nsum_z[i] = '0; face_cnt[i] = '0;
    end
    amb_lvl = AMB_RST; atten_lvl = ATT_RST;
    lite_x = LX_RST; lite_y = LY_RST; lite_z = LZ_RST;

    // directed words: extremes, fresh vertices, skip, degenerate face, unused code
    dir_rows.push_back(row(CMD_LOAD, 0, 0, 0, -2048, -2048, -2048, 0, 0));
    dir_rows.push_back(row(CMD_LOAD, 1, 0, 0, 2047, -2048, 0, 0, 0));
    dir_rows.push_back(row(CMD_LOAD, 2, 0, 0, 0, 2047, -2048, 0, 0));
    dir_rows.push_back(row(CMD_LOAD, 1023, 0, 0, 2047, 2047, 2047, 0, 0));
    // no faces yet: ambient 64 alone, full lightness -> 63
    dir_rows.push_back(row(CMD_LIGHT, 0, 1, 2, 0, 0, 0, 16'hffff, 0, 1,
                           '{16'hffbf, 16'hffbf, 16'hffbf, 1'b0}));
    // zero lightness clamps to the floor
    dir_rows.push_back(row(CMD_LIGHT, 1023, 1023, 1023, 0, 0, 0, 16'h0000, 1, 1,
                           '{16'h0002, 16'h0002, 16'h0002, 1'b0}));
    dir_rows.push_back(row(CMD_LIGHT, 0, 1, 2, 0, 0, 0, 16'hffff, FACE_SKIP, 1,
                           '{16'h0000, 16'h0000, 16'h0000, 1'b1}));
    dir_rows.push_back(row(CMD_ACCUM, 0, 1, 2, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_ACCUM, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_ACCUM, 1023, 0, 1, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_NONE, 5, 6, 7, 1, 2, 3, 16'h1234, 0));
    dir_rows.push_back(row(CMD_LIGHT, 0, 1, 2, 0, 0, 0, 16'hffff, 3));
    dir_rows.push_back(row(CMD_LIGHT, 1023, 2, 0, 0, 0, 0, 16'h1234, 1));
    dir_rows.push_back(row(CMD_LOAD, 0, 0, 0, 5, -7, 9, 0, 0));
    dir_rows.push_back(row(CMD_ACCUM, 2, 1, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(row(CMD_LIGHT, 2, 1, 0, 0, 0, 0, 16'h807f, 0));
    dir_rows.push_back(row(CMD_LIGHT, 5, 1023, 0, 0, 0, 0, 16'h7f40, 2));

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    set_lighting(AMB_RST, ATT_RST, LX_RST, LY_RST, LZ_RST);

    foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].res);
    settle();

    // random phases over several lighting setups, extremes included
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_lighting(255, 1, 1023, 1023, 1023);
        1: set_lighting(0, 4095, -1024, -1024, -1024);
        2: set_lighting(128, 1, -1024, 1023, -1024);
        3: set_lighting($urandom_range(0, 255), $urandom_range(1, 4095),
                        $urandom_range(0, 2047), $urandom_range(0, 2047),
                        $urandom_range(0, 2047));
        default: set_lighting(AMB_RST, 200, -300, 700, 100);
      endcase
      quiet = (ph == 4);
      for (int i = 0; i < RAND_WORDS / 5; i++) begin
        if (ph == 1 && i == 20) hold_req = 1'b1;
        w = rand_word();
        send_word(w);
      end
      settle();
    end

    $display("Covered %0d loads, %0d accumulates, %0d light faces (%0d skipped);",
             n_load, n_accum, n_light, n_skip);
    $display("%0d lit face words checked across 6 lighting setups.", n_checked);
    if (errors == 0 && pending_faces.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
rtl/vngl_pkg.sv
rtl/vertex_normal_gouraud_lighting.sv
bench/tb_vertex_normal_gouraud_lighting.sv
